>>> rtl/dual_bank_image_crc_validator_top_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the dual bank image crc validator
// ----------------------------------------------------------------------------
`ifndef DUAL_BANK_IMAGE_CRC_VALIDATOR_TOP_ASSERT_SVH
`define DUAL_BANK_IMAGE_CRC_VALIDATOR_TOP_ASSERT_SVH

// property checked only while out of reset
`define DBCV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define DBCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/dbcv_pkg.sv
// ----------------------------------------------------------------------------
// dbcv_pkg
// shared types, constants and the crc-16 byte update of the image validator
// ----------------------------------------------------------------------------
package dbcv_pkg;

  // image geometry
  localparam int unsigned ImageBytes = 1024;
  localparam int unsigned BodyBytes  = ImageBytes - 4;
  localparam int unsigned CntW       = $clog2(ImageBytes + 1);
  localparam int unsigned NumBanks   = 2;

  // crc-16/modbus
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [0:0] {
    OpByte    = 1'b0,
    OpRestart = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SelNone = 2'd0,
    SelA    = 2'd1,
    SelB    = 2'd2
  } sel_e;

  typedef struct packed {
    op_e        operation;
    logic       bank;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        bank_done;
    logic        bank_valid;
    logic [15:0] crc_value;
    logic [1:0]  selected_bank;
    logic        restore_ok;
  } out_item_t;

  // reflected crc update over one byte, lsb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/dbcv_if.sv
// ----------------------------------------------------------------------------
// dbcv stream interfaces
// valid/ready channels for input bytes and for result transactions
// ----------------------------------------------------------------------------
interface dbcv_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       bank;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output bank, output data_byte,
                  input ready);
  modport sink   (input valid, input operation, input bank, input data_byte,
                  output ready);
endinterface

interface dbcv_out_if;
  logic        valid;
  logic        ready;
  logic        bank_done;
  logic        bank_valid;
  logic [15:0] crc_value;
  logic [1:0]  selected_bank;
  logic        restore_ok;

  modport source (output valid, output bank_done, output bank_valid,
                  output crc_value, output selected_bank, output restore_ok,
                  input ready);
  modport sink   (input valid, input bank_done, input bank_valid,
                  input crc_value, input selected_bank, input restore_ok,
                  output ready);
endinterface

>>> rtl/dbcv_in_reg.sv
// ----------------------------------------------------------------------------
// dbcv_in_reg
// input register stage: holds one transaction ahead of the check core
// ----------------------------------------------------------------------------
module dbcv_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dbcv_pkg::in_item_t in_item_i,
  output logic               stg_valid_o,
  input  logic               stg_ready_i,
  output dbcv_pkg::in_item_t stg_item_o
);

  logic               valid_q, valid_d;
  dbcv_pkg::in_item_t item_q;

  // take a new transaction when empty or when the held one moves on
  assign in_ready_o = !valid_q || stg_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stg_valid_o = valid_q;
  assign stg_item_o  = item_q;

endmodule

>>> rtl/dbcv_core.sv
// ----------------------------------------------------------------------------
// dbcv_core
// per-bank crc, trailer word and completion state, bank choice, result register
// ----------------------------------------------------------------------------
module dbcv_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                stg_valid_i,
  output logic                stg_ready_o,
  input  dbcv_pkg::in_item_t  stg_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dbcv_pkg::out_item_t out_item_o
);

  logic [15:0]               crc_q  [dbcv_pkg::NumBanks];
  logic [15:0]               crc_d  [dbcv_pkg::NumBanks];
  logic [dbcv_pkg::CntW-1:0] cnt_q  [dbcv_pkg::NumBanks];
  logic [dbcv_pkg::CntW-1:0] cnt_d  [dbcv_pkg::NumBanks];
  logic [31:0]               word_q [dbcv_pkg::NumBanks];
  logic [31:0]               word_d [dbcv_pkg::NumBanks];
  logic [dbcv_pkg::NumBanks-1:0] cmp_q, cmp_d;
  logic [dbcv_pkg::NumBanks-1:0] ok_q, ok_d;
  logic [1:0]                pref_q;

  logic                      fire;
  logic                      bsel;
  logic [dbcv_pkg::CntW-1:0] cnt_cur;
  logic [dbcv_pkg::CntW-1:0] cnt_inc;
  logic [1:0]                pos;
  logic [15:0]               crc_upd;
  logic [31:0]               shifted;
  logic                      done;
  logic                      valid;
  logic [15:0]               crc_res;
  dbcv_pkg::sel_e            sel;

  logic                      out_valid_q;
  dbcv_pkg::out_item_t       out_item_q, out_item_d;

  assign stg_ready_o = !out_valid_q || out_ready_i;
  assign fire        = stg_valid_i && stg_ready_o;

  // datapath terms for the addressed bank
  assign bsel    = stg_item_i.bank;
  assign cnt_cur = cnt_q[bsel];
  assign cnt_inc = cnt_cur + 1'b1;
  assign pos     = cnt_cur[1:0] - 2'(dbcv_pkg::BodyBytes);
  assign crc_upd = dbcv_pkg::crc16_byte(crc_q[bsel], stg_item_i.data_byte);
  assign shifted = {24'h000000, stg_item_i.data_byte} << {pos, 3'b000};

  // next state of the bank set
  always_comb begin
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    cmp_d   = cmp_q;
    ok_d    = ok_q;
    done    = 1'b0;
    valid   = 1'b0;
    crc_res = dbcv_pkg::CrcInit;
    unique case (stg_item_i.operation)
      dbcv_pkg::OpRestart: begin
        for (int i = 0; i < dbcv_pkg::NumBanks; i++) begin
          crc_d[i]  = dbcv_pkg::CrcInit;
          cnt_d[i]  = '0;
          word_d[i] = '0;
        end
        cmp_d   = '0;
        ok_d    = '0;
        crc_res = dbcv_pkg::CrcInit;
      end
      dbcv_pkg::OpByte: begin
        // bytes past the end of a completed bank leave it untouched
        if (!cmp_q[bsel]) begin
          if (cnt_cur < dbcv_pkg::CntW'(dbcv_pkg::BodyBytes)) begin
            crc_d[bsel] = crc_upd;
          end else begin
            word_d[bsel] = word_q[bsel] | shifted;
          end
          cnt_d[bsel] = cnt_inc;
          if (cnt_inc >= dbcv_pkg::CntW'(dbcv_pkg::ImageBytes)) begin
            cmp_d[bsel] = 1'b1;
            ok_d[bsel]  = (word_d[bsel] == {16'h0000, crc_d[bsel]});
            done        = 1'b1;
            valid       = ok_d[bsel];
          end
        end
        crc_res = crc_d[bsel];
      end
      default: begin
        crc_res = dbcv_pkg::CrcInit;
      end
    endcase
  end

  // bank choice: preferred if good, else a, else b
  always_comb begin
    priority if (pref_q == dbcv_pkg::SelA && ok_d[0]) begin
      sel = dbcv_pkg::SelA;
    end else if (pref_q == dbcv_pkg::SelB && ok_d[1]) begin
      sel = dbcv_pkg::SelB;
    end else if (ok_d[0]) begin
      sel = dbcv_pkg::SelA;
    end else if (ok_d[1]) begin
      sel = dbcv_pkg::SelB;
    end else begin
      sel = dbcv_pkg::SelNone;
    end
  end

  always_comb begin
    out_item_d.bank_done     = done;
    out_item_d.bank_valid    = valid;
    out_item_d.crc_value     = crc_res;
    out_item_d.selected_bank = sel;
    out_item_d.restore_ok    = (sel != dbcv_pkg::SelNone);
  end

  // bank state and preference register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dbcv_pkg::NumBanks; i++) begin
        crc_q[i]  <= dbcv_pkg::CrcInit;
        cnt_q[i]  <= '0;
        word_q[i] <= '0;
      end
      cmp_q  <= '0;
      ok_q   <= '0;
      pref_q <= dbcv_pkg::SelNone;
    end else begin
      if (fire) begin
        crc_q  <= crc_d;
        cnt_q  <= cnt_d;
        word_q <= word_d;
        cmp_q  <= cmp_d;
        ok_q   <= ok_d;
      end
      if (cfg_we_i) begin
        pref_q <= cfg_wdata_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_ready_o) begin
      out_valid_q <= stg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/dual_bank_image_crc_validator_top.sv
// an accepted transaction passes the input register, then the result register
// throughput: one byte per cycle while results are taken, set by the unrolled eight-bit crc update
// the input register and the result register both move while the sink takes results
// reset: asynchronous, clears both banks and the preferred bank at once
// no clearing pass: the block takes bytes in the first cycle after reset
// ----------------------------------------------------------------------------
// dual_bank_image_crc_validator_top
// crc-16/modbus check of two image banks with preferred-bank selection
// ----------------------------------------------------------------------------
module dual_bank_image_crc_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  dbcv_in_if.sink    in_i,
  dbcv_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  dbcv_pkg::in_item_t  in_item;
  dbcv_pkg::in_item_t  stg_item;
  dbcv_pkg::out_item_t out_item;
  logic                stg_valid;
  logic                stg_ready;

  // pack the input transaction
  assign in_item.operation = dbcv_pkg::op_e'(in_i.operation);
  assign in_item.bank      = in_i.bank;
  assign in_item.data_byte = in_i.data_byte;

  dbcv_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .stg_valid_o (stg_valid),
    .stg_ready_i (stg_ready),
    .stg_item_o  (stg_item)
  );

  dbcv_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stg_valid_i (stg_valid),
    .stg_ready_o (stg_ready),
    .stg_item_i  (stg_item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  // unpack the result transaction
  assign out_o.bank_done     = out_item.bank_done;
  assign out_o.bank_valid    = out_item.bank_valid;
  assign out_o.crc_value     = out_item.crc_value;
  assign out_o.selected_bank = out_item.selected_bank;
  assign out_o.restore_ok    = out_item.restore_ok;

endmodule

>>> rtl/dbcv_checker.sv
// ----------------------------------------------------------------------------
// dbcv_checker
// port-level checks of the image validator, bound to the top level
// ----------------------------------------------------------------------------
`include "dual_bank_image_crc_validator_top_assert.svh"

module dbcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        bank_done_i,
  input logic        bank_valid_i,
  input logic [15:0] crc_value_i,
  input logic [1:0]  selected_bank_i,
  input logic        restore_ok_i
);

  // no result straight out of reset
  `DBCV_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_i, "result after reset")

  // restore flag follows the selection
  `DBCV_ASSERT(a_restore_sel, clk_i, rst_ni, out_valid_i |-> (restore_ok_i == (selected_bank_i != 2'd0)), "restore_ok mismatch")

  // only banks a and b may be selected
  `DBCV_ASSERT(a_sel_code, clk_i, rst_ni, out_valid_i |-> (selected_bank_i != 2'd3), "bad bank code")

  // a valid flag only on the completing transaction
  `DBCV_ASSERT(a_valid_done, clk_i, rst_ni, (out_valid_i && bank_valid_i) |-> bank_done_i, "valid without done")

  // stalled result keeps its crc value and bank selection
  `DBCV_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(crc_value_i) && $stable(selected_bank_i)), "stalled result changed")

endmodule

bind dual_bank_image_crc_validator_top dbcv_checker u_dbcv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .bank_done_i     (out_o.bank_done),
  .bank_valid_i    (out_o.bank_valid),
  .crc_value_i     (out_o.crc_value),
  .selected_bank_i (out_o.selected_bank),
  .restore_ok_i    (out_o.restore_ok)
);
